// ----- rtl/go_to_goal_steering_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the go-to-goal steering core
// Implication checks, same cycle and next cycle, switched off by NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef GO_TO_GOAL_STEERING_CORE_MACROS_SVH
`define GO_TO_GOAL_STEERING_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ggs assertion failed");
`define GGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ggs assertion failed");
`else
`define GGS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GGS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/ggs_pkg.sv -----
// ---------------------------------------------------------------------------
// ggs_pkg
// Types, constants and the arctangent table of the go-to-goal steering core.
// ---------------------------------------------------------------------------
package ggs_pkg;

  localparam int XW = 28;   // CORDIC x/y, Q.16 with growth headroom
  localparam int ZW = 20;   // CORDIC angle, Q.16 radians
  localparam int HW = 15;   // heading / angle fields, Q3.12

  localparam logic signed [ZW-1:0] HALF_PI_Q16   = 20'sd102944;
  localparam logic [15:0]          GAIN_COMP_Q16 = 16'd39797;

  // configuration register indexes
  localparam logic [2:0] REG_GOAL_X        = 3'd0;
  localparam logic [2:0] REG_GOAL_Y        = 3'd1;
  localparam logic [2:0] REG_SPEED_GAIN    = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT   = 3'd3;
  localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd4;
  localparam logic [2:0] REG_AIM_TOLERANCE = 3'd5;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [HW-1:0] hd;
  } ggs_vec_t;

  typedef struct packed {
    logic [15:0]   speed_gain;
    logic [15:0]   speed_limit;
    logic [15:0]   arrive_radius;
    logic [HW-1:0] aim_tolerance;
  } ggs_cmd_cfg_t;

  // round(atan(2^-i) * 65536)
  function automatic logic [15:0] atan_q16(input int idx);
    logic [15:0] t;
    case (idx)
      0:       t = 16'd51472;
      1:       t = 16'd30386;
      2:       t = 16'd16055;
      3:       t = 16'd8150;
      4:       t = 16'd4091;
      5:       t = 16'd2047;
      6:       t = 16'd1024;
      7:       t = 16'd512;
      8:       t = 16'd256;
      9:       t = 16'd128;
      10:      t = 16'd64;
      11:      t = 16'd32;
      12:      t = 16'd16;
      13:      t = 16'd8;
      14:      t = 16'd4;
      15:      t = 16'd2;
      16:      t = 16'd1;
      default: t = 16'd0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/ggs_front.sv -----
// ---------------------------------------------------------------------------
// ggs_front
// Goal offset and quadrant pre-rotation into the CORDIC working format.
// ---------------------------------------------------------------------------
module ggs_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [15:0]           goal_x,
  input  logic signed [15:0]           goal_y,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic signed [15:0]           pos_x,
  input  logic signed [15:0]           pos_y,
  input  logic signed [ggs_pkg::HW-1:0] heading,
  output logic                         m_valid,
  input  logic                         m_ready,
  output ggs_pkg::ggs_vec_t            m_data
);

  logic signed [16:0] dx, dy, x17, y17;
  logic signed [ggs_pkg::ZW-1:0] z0;
  ggs_pkg::ggs_vec_t d_nxt, d_r;
  logic v_r;

  always_comb begin
    dx = {goal_x[15], goal_x} - {pos_x[15], pos_x};
    dy = {goal_y[15], goal_y} - {pos_y[15], pos_y};
    if (dx[16]) begin
      if (!dy[16]) begin
        x17 = dy;
        y17 = -dx;
        z0  = ggs_pkg::HALF_PI_Q16;
      end else begin
        x17 = -dy;
        y17 = dx;
        z0  = -ggs_pkg::HALF_PI_Q16;
      end
    end else begin
      x17 = dx;
      y17 = dy;
      z0  = '0;
    end
    d_nxt.x  = {{(ggs_pkg::XW-25){x17[16]}}, x17, 8'b0};
    d_nxt.y  = {{(ggs_pkg::XW-25){y17[16]}}, y17, 8'b0};
    d_nxt.z  = z0;
    d_nxt.hd = heading;
  end

  assign s_ready = !v_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (s_ready) begin
      v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      d_r <= d_nxt;
    end
  end

  assign m_valid = v_r;
  assign m_data  = d_r;

endmodule

// ----- rtl/ggs_cordic_stage.sv -----
// ---------------------------------------------------------------------------
// ggs_cordic_stage
// One registered vectoring-mode CORDIC micro-rotation.
// ---------------------------------------------------------------------------
module ggs_cordic_stage #(
  parameter int STEP_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  output logic              s_ready,
  input  ggs_pkg::ggs_vec_t s_data,
  output logic              m_valid,
  input  logic              m_ready,
  output ggs_pkg::ggs_vec_t m_data
);

  logic signed [ggs_pkg::XW-1:0] x, y, xs, ys;
  logic signed [ggs_pkg::ZW-1:0] z, t;
  ggs_pkg::ggs_vec_t d_nxt, d_r;
  logic v_r;

  always_comb begin
    x  = s_data.x;
    y  = s_data.y;
    z  = s_data.z;
    xs = x >>> STEP_IDX;
    ys = y >>> STEP_IDX;
    t  = $signed({{(ggs_pkg::ZW-16){1'b0}}, ggs_pkg::atan_q16(STEP_IDX)});
    d_nxt.hd = s_data.hd;
    if (!y[ggs_pkg::XW-1]) begin
      d_nxt.x = x + ys;
      d_nxt.y = y - xs;
      d_nxt.z = z + t;
    end else begin
      d_nxt.x = x - ys;
      d_nxt.y = y + xs;
      d_nxt.z = z - t;
    end
  end

  assign s_ready = !v_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (s_ready) begin
      v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      d_r <= d_nxt;
    end
  end

  assign m_valid = v_r;
  assign m_data  = d_r;

endmodule

// ----- rtl/ggs_back.sv -----
// ---------------------------------------------------------------------------
// ggs_back
// Gain compensation, bearing error, arrival/aim decision and speed command.
// Four register stages, the last one is the output register.
// ---------------------------------------------------------------------------
`include "go_to_goal_steering_core_macros.svh"

module ggs_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ggs_pkg::ggs_cmd_cfg_t     cfg,
  input  logic                      s_valid,
  output logic                      s_ready,
  input  ggs_pkg::ggs_vec_t         s_data,
  output logic                      m_valid,
  input  logic                      m_ready,
  output logic [15:0]               linear_speed,
  output logic [ggs_pkg::HW-1:0]    angular_rate
);

  // stage 1: distance product and bearing error
  logic                 v1_r, rdy1;
  logic [42:0]          prod1_r, prod1_nxt;
  logic signed [16:0]   err1_r, err1_nxt;
  logic [26:0]          xpos;
  logic signed [ggs_pkg::ZW-1:0] zr;
  logic signed [15:0]   bearing;

  // stage 2: rounded distance and decision flags
  logic                 v2_r, rdy2;
  logic [16:0]          dist2_r, dist2_nxt;
  logic                 near2_r, near2_nxt, turn2_r, turn2_nxt;
  logic [ggs_pkg::HW-1:0] aerr2_r;
  logic [42:0]          rnd_sum;
  logic [16:0]          aerr_full;

  // stage 3: gain product
  logic                 v3_r, rdy3;
  logic [32:0]          prod3_r;
  logic                 near3_r, turn3_r;
  logic [ggs_pkg::HW-1:0] aerr3_r;

  // stage 4: output register
  logic                 v4_r, rdy4;
  logic [15:0]          lin4_r, lin4_nxt;
  logic [ggs_pkg::HW-1:0] ang4_r, ang4_nxt;
  logic [24:0]          spd;

  assign rdy4    = !v4_r || m_ready;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign s_ready = rdy1;

  always_comb begin
    xpos      = s_data.x[ggs_pkg::XW-1] ? 27'd0 : s_data.x[26:0];
    prod1_nxt = {16'd0, xpos} * {27'd0, ggs_pkg::GAIN_COMP_Q16};
    zr        = (s_data.z + 20'sd8) >>> 4;
    bearing   = zr[15:0];
    err1_nxt  = {bearing[15], bearing} - {{2{s_data.hd[ggs_pkg::HW-1]}}, s_data.hd};
  end

  always_comb begin
    rnd_sum   = prod1_r + 43'd8388608;
    dist2_nxt = rnd_sum[40:24];
    near2_nxt = dist2_nxt <= {1'b0, cfg.arrive_radius};
    aerr_full = err1_r[16] ? 17'(-err1_r) : 17'(err1_r);
    turn2_nxt = aerr_full > {2'b0, cfg.aim_tolerance};
  end

  always_comb begin
    spd      = prod3_r[32:8];
    lin4_nxt = '0;
    ang4_nxt = '0;
    if (!near3_r) begin
      if (turn3_r) begin
        ang4_nxt = aerr3_r;
      end else if (spd > {9'd0, cfg.speed_limit}) begin
        lin4_nxt = cfg.speed_limit;
      end else begin
        lin4_nxt = spd[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= s_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_valid) begin
      prod1_r <= prod1_nxt;
      err1_r  <= err1_nxt;
    end
    if (rdy2 && v1_r) begin
      dist2_r <= dist2_nxt;
      near2_r <= near2_nxt;
      turn2_r <= turn2_nxt;
      aerr2_r <= aerr_full[ggs_pkg::HW-1:0];
    end
    if (rdy3 && v2_r) begin
      prod3_r <= {17'd0, cfg.speed_gain} * {16'd0, dist2_r};
      near3_r <= near2_r;
      turn3_r <= turn2_r;
      aerr3_r <= aerr2_r;
    end
    if (rdy4 && v3_r) begin
      lin4_r <= lin4_nxt;
      ang4_r <= ang4_nxt;
    end
  end

  assign m_valid      = v4_r;
  assign linear_speed = lin4_r;
  assign angular_rate = ang4_r;

  `GGS_ASSERT_IMP(a_cmd_exclusive, clk, rst_n, v4_r, (lin4_r == '0) || (ang4_r == '0))
  `GGS_ASSERT_IMP(a_speed_capped, clk, rst_n, v4_r, lin4_r <= cfg.speed_limit)
  `GGS_ASSERT_IMP(a_turn_above_tol, clk, rst_n, v4_r && (ang4_r != '0), ang4_r > cfg.aim_tolerance)
  `GGS_ASSERT_NXT(a_full_holds, clk, rst_n, !rdy1 && !m_ready, v4_r)

endmodule

// ----- rtl/go_to_goal_steering_core.sv -----
// Path from input item to result item: the ggs_front register, the CORDIC stage registers and the ggs_back registers.
// Throughput: one item per cycle while no stage stalls; every stage is a register with its own valid bit.
// A full stage stalls only when the stage after it is full and not advancing.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads register defaults.
// ---------------------------------------------------------------------------
// go_to_goal_steering_core
// Proportional go-to-goal steering: goal offset, pipelined CORDIC, command logic.
// ---------------------------------------------------------------------------
module go_to_goal_steering_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32], zero[47]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // linear_speed[15:0], angular_rate[30:16], zero[31]
);

  logic signed [15:0] goal_x_r, goal_y_r;
  logic [15:0] speed_gain_r, speed_limit_r, arrive_radius_r;
  logic [ggs_pkg::HW-1:0] aim_tolerance_r;
  ggs_pkg::ggs_cmd_cfg_t cmd_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r        <= 16'sd256;
      goal_y_r        <= 16'sd256;
      speed_gain_r    <= 16'd256;
      speed_limit_r   <= 16'd256;
      arrive_radius_r <= 16'd26;
      aim_tolerance_r <= 15'd819;
    end else if (cfg_valid) begin
      case (cfg_addr)
        ggs_pkg::REG_GOAL_X:        goal_x_r        <= cfg_data;
        ggs_pkg::REG_GOAL_Y:        goal_y_r        <= cfg_data;
        ggs_pkg::REG_SPEED_GAIN:    speed_gain_r    <= cfg_data;
        ggs_pkg::REG_SPEED_LIMIT:   speed_limit_r   <= cfg_data;
        ggs_pkg::REG_ARRIVE_RADIUS: arrive_radius_r <= cfg_data;
        ggs_pkg::REG_AIM_TOLERANCE: aim_tolerance_r <= cfg_data[ggs_pkg::HW-1:0];
        default: ;
      endcase
    end
  end

  assign cmd_cfg.speed_gain    = speed_gain_r;
  assign cmd_cfg.speed_limit   = speed_limit_r;
  assign cmd_cfg.arrive_radius = arrive_radius_r;
  assign cmd_cfg.aim_tolerance = aim_tolerance_r;

  logic              st_valid [CORDIC_STEPS+1];
  logic              st_ready [CORDIC_STEPS+1];
  ggs_pkg::ggs_vec_t st_data  [CORDIC_STEPS+1];

  ggs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .goal_x  (goal_x_r),
    .goal_y  (goal_y_r),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .pos_x   (in_tdata[15:0]),
    .pos_y   (in_tdata[31:16]),
    .heading (in_tdata[46:32]),
    .m_valid (st_valid[0]),
    .m_ready (st_ready[0]),
    .m_data  (st_data[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    ggs_cordic_stage #(
      .STEP_IDX (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .s_valid (st_valid[i]),
      .s_ready (st_ready[i]),
      .s_data  (st_data[i]),
      .m_valid (st_valid[i+1]),
      .m_ready (st_ready[i+1]),
      .m_data  (st_data[i+1])
    );
  end

  logic [15:0]            lin;
  logic [ggs_pkg::HW-1:0] ang;

  ggs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cmd_cfg),
    .s_valid      (st_valid[CORDIC_STEPS]),
    .s_ready      (st_ready[CORDIC_STEPS]),
    .s_data       (st_data[CORDIC_STEPS]),
    .m_valid      (out_tvalid),
    .m_ready      (out_tready),
    .linear_speed (lin),
    .angular_rate (ang)
  );

  assign out_tdata = {1'b0, ang, lin};

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// go_to_goal_steering_core testbench
// Streams pose samples into the steering core and checks every command item
// against an in-bench fixed-point CORDIC predictor. Registers are reloaded
// between phases while the core is idle. Both stream sides idle in random
// bursts, and one long output hold-off makes the input side stall.
// ---------------------------------------------------------------------------
module testbench;

  localparam int STEPS       = 16;
  localparam int LATENCY     = STEPS + 5;
  localparam int HOLD_CYCLES = 150;

  localparam logic [2:0] REG_SPARE    = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam longint ATAN_Q16 [24] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };
  localparam longint HALF_PI    = 102944;
  localparam longint GAIN_COMP  = 39797;

  typedef struct packed {
    logic [14:0] angular_rate;
    logic [15:0] linear_speed;
  } steer_cmd_t;

  class steer_scoreboard;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [15:0]        speed_gain;
    logic [15:0]        speed_limit;
    logic [15:0]        arrive_radius;
    logic [14:0]        aim_tolerance;
    steer_cmd_t         cmd_q[$];
    int                 errors;
    int                 results;

    function new();
      goal_x        = 16'sd256;
      goal_y        = 16'sd256;
      speed_gain    = 16'd256;
      speed_limit   = 16'd256;
      arrive_radius = 16'd26;
      aim_tolerance = 15'd819;
      errors        = 0;
      results       = 0;
    endfunction

    function void write_reg(input logic [2:0] addr, input logic [15:0] data);
      case (addr)
        ggs_pkg::REG_GOAL_X:        goal_x = data;
        ggs_pkg::REG_GOAL_Y:        goal_y = data;
        ggs_pkg::REG_SPEED_GAIN:    speed_gain = data;
        ggs_pkg::REG_SPEED_LIMIT:   speed_limit = data;
        ggs_pkg::REG_ARRIVE_RADIUS: arrive_radius = data;
        ggs_pkg::REG_AIM_TOLERANCE: aim_tolerance = data[14:0];
        default: ;
      endcase
    endfunction

    // vectoring CORDIC on the goal offset: Q8.8 distance, Q3.12 bearing
    function void cordic_polar(input logic signed [15:0] px, input logic signed [15:0] py,
                               output longint dist_q8, output longint bearing);
      longint dx, dy, x, y, z, xs, ys;
      dx = longint'(goal_x) - longint'(px);
      dy = longint'(goal_y) - longint'(py);
      z  = 0;
      if (dx < 0) begin
        if (dy >= 0) begin
          x = dy;
          y = -dx;
          z = HALF_PI;
        end else begin
          x = -dy;
          y = dx;
          z = -HALF_PI;
        end
      end else begin
        x = dx;
        y = dy;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += ATAN_Q16[i];
        end else begin
          x -= ys;
          y += xs;
          z -= ATAN_Q16[i];
        end
      end
      if (x < 0) x = 0;
      dist_q8 = (x * GAIN_COMP + (longint'(1) <<< 23)) >>> 24;
      bearing = (z + 8) >>> 4;
    endfunction

    function void note_pose(input logic [47:0] tdata);
      logic signed [15:0] px, py;
      logic signed [14:0] hd;
      longint dist_q8, bearing, err, lin, ang;
      steer_cmd_t cmd;
      px = tdata[15:0];
      py = tdata[31:16];
      hd = tdata[46:32];
      cordic_polar(px, py, dist_q8, bearing);
      err = bearing - longint'(hd);
      if (err < 0) err = -err;
      lin = 0;
      ang = 0;
      if (dist_q8 > longint'(arrive_radius)) begin
        if (err > longint'(aim_tolerance)) begin
          ang = err;
        end else begin
          lin = (longint'(speed_gain) * dist_q8) >>> 8;
          if (lin > longint'(speed_limit)) lin = longint'(speed_limit);
        end
      end
      cmd.linear_speed = lin[15:0];
      cmd.angular_rate = ang[14:0];
      cmd_q.push_back(cmd);
    endfunction

    function void report(input string msg);
      errors++;
      if (errors <= 10) $display("ERROR: result %0d: %s", results, msg);
    endfunction

    function void check_cmd(input logic [31:0] tdata);
      steer_cmd_t want, got;
      got = tdata[30:0];
      if (cmd_q.size() == 0) begin
        report($sformatf("unexpected item %h", tdata));
      end else begin
        want = cmd_q.pop_front();
        if (got.linear_speed !== want.linear_speed)
          report($sformatf("linear_speed expected %0d got %0d",
                           want.linear_speed, got.linear_speed));
        if (got.angular_rate !== want.angular_rate)
          report($sformatf("angular_rate expected %0d got %0d",
                           want.angular_rate, got.angular_rate));
      end
      results++;
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // pos_x[15:0], pos_y[31:16], heading[46:32], zero[47]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // linear_speed[15:0], angular_rate[30:16], zero[31]

  bit              no_gaps;
  bit              hold_req;
  steer_scoreboard sb;

  go_to_goal_steering_core #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_addr, cfg_data);
    if (rst_n && in_tvalid && in_tready) sb.note_pose(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_cmd(out_tdata);
  end

  initial begin
    #400000;
    $display("go_to_goal_steering_core verification failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [15:0] data);
    cfg_addr  = addr;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_setting(input logic [15:0] gx, input logic [15:0] gy,
                              input logic [15:0] gain, input logic [15:0] lim,
                              input logic [15:0] rad, input logic [15:0] tol);
    cfg_write(ggs_pkg::REG_GOAL_X, gx);
    cfg_write(ggs_pkg::REG_GOAL_Y, gy);
    cfg_write(ggs_pkg::REG_SPEED_GAIN, gain);
    cfg_write(ggs_pkg::REG_SPEED_LIMIT, lim);
    cfg_write(ggs_pkg::REG_ARRIVE_RADIUS, rad);
    cfg_write(ggs_pkg::REG_AIM_TOLERANCE, tol);
  endtask

  task automatic push_pose(input logic [15:0] px, input logic [15:0] py,
                           input logic [14:0] hd);
    in_tdata  = {1'b0, hd, py, px};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (!no_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // mix of raw noise, poses near the goal and poses roughly aimed at it
  task automatic random_poses(input int count);
    logic [15:0] px, py;
    logic [14:0] hd;
    longint      dist_q8, brg, jitter;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1)) begin
        px = sb.goal_x + 16'($urandom_range(0, 1023)) - 16'd512;
        py = sb.goal_y + 16'($urandom_range(0, 1023)) - 16'd512;
      end else begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      case ($urandom_range(0, 3))
        0: hd = 15'($urandom);
        1: hd = 15'($urandom_range(0, 25736) - 12868);
        default: begin
          sb.cordic_polar(px, py, dist_q8, brg);
          jitter = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, 1200)) - 600;
          hd = 15'(brg + jitter);
        end
      endcase
      push_pose(px, py, hd);
    end
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr  = '0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    no_gaps   = 1'b0;
    hold_req  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // register defaults: goal at (1.0, 1.0)
    push_pose(16'sd256, 16'sd256, 15'sd0);
    push_pose(16'sd0, 16'sd256, 15'sd0);
    push_pose(16'sd0, 16'sd256, 15'sd6434);
    push_pose(16'sd250, 16'sd260, 15'sd0);
    push_pose(16'sd512, 16'sd256, 15'sd0);
    push_pose(16'sd512, 16'sd512, 15'sd0);
    push_pose(16'sd256, 16'sd512, -15'sd6434);
    push_pose(16'sd0, 16'sd0, 15'sd3217);
    push_pose(16'h8000, 16'h8000, 15'sd12868);
    push_pose(16'sd32767, 16'sd32767, -15'sd12868);
    push_pose(16'h8000, 16'sd32767, 15'h4000);
    push_pose(16'sd32767, 16'h8000, 15'sd16383);
    push_pose(16'h8000, 16'sd256, 15'sd0);
    push_pose(16'sd256, 16'h8000, 15'sd6434);
    drain();

    // extremes: far goal corner, full gain and limit, zero radius and tolerance
    load_setting(16'h8000, 16'h7fff, 16'hffff, 16'hffff, 16'd0, 16'd0);
    push_pose(16'h8000, 16'h7fff, 15'sd0);
    push_pose(16'h7fff, 16'h8000, 15'sd0);
    push_pose(16'h7fff, 16'h8000, 15'sd9651);
    push_pose(16'h8000, 16'h7ff0, -15'sd6434);
    hold_req = 1'b1;
    random_poses(130);
    drain();

    // opposite extremes: zero gain and limit, full radius, top tolerance
    load_setting(16'h7fff, 16'h8000, 16'd0, 16'd0, 16'hffff, 16'd25736);
    random_poses(100);
    drain();

    cfg_write(REG_SPARE, 16'($urandom));
    cfg_write(REG_SPARE_HI, 16'($urandom));
    load_setting(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4096)), 16'($urandom),
                 16'($urandom_range(0, 512)), 16'hffff);
    random_poses(100);
    drain();

    for (int p = 0; p < 4; p++) begin
      no_gaps = (p == 1);
      load_setting($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2048)),
                   $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2048)),
                   $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1024)),
                   16'($urandom),
                   $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 256)),
                   16'($urandom));
      random_poses(90);
      drain();
    end

    no_gaps = 1'b1;
    load_setting(16'sd1280, -16'sd768, 16'd512, 16'd1024, 16'd26, 16'd819);
    random_poses(110);
    drain();
    repeat (LATENCY + 10) @(negedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("go_to_goal_steering_core verification clean");
    end else begin
      $display("go_to_goal_steering_core verification failed");
    end
    $finish;
  end

endmodule
